// ----- src/sasf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sasf_pkg: shared types and codes of the source address filter
// Command and status codes, field widths and the records that travel
// between the front queue, the back engine and the top level.
// ----------------------------------------------------------------------------
package sasf_pkg;

    localparam int CMD_W   = 3;
    localparam int ADDR_W  = 48;
    localparam int BYTES_W = 16;
    localparam int STAT_W  = 3;
    localparam int MSG_W   = 32;
    localparam int CNT_W   = 48;

    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RECV   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SENT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_DUP       = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] STAT_DROPPED   = 3'd4;

    // One queued command, with its class worked out on entry.
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ADDR_W-1:0]  addr;
        logic [BYTES_W-1:0] bytes;
        logic               needs_scan;
    } front_item_t;

    // One result beat.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [MSG_W-1:0]  round_number;
        logic [MSG_W-1:0]  period_msgs_sent;
        logic [CNT_W-1:0]  period_bytes_sent;
        logic [MSG_W-1:0]  all_msgs_sent;
        logic [CNT_W-1:0]  all_bytes_sent;
        logic [MSG_W-1:0]  period_msgs_received;
        logic [CNT_W-1:0]  period_bytes_received;
        logic [MSG_W-1:0]  all_msgs_received;
        logic [CNT_W-1:0]  all_bytes_received;
    } result_t;

endpackage

`default_nettype wire

// ----- src/sasf_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sasf_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sasf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ----- src/sasf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sasf_front: command intake and classification
// Takes command beats into a two-entry queue and marks the ones that need
// a table scan.
// ----------------------------------------------------------------------------
module sasf_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [sasf_pkg::CMD_W-1:0]     command,
    input  wire logic [sasf_pkg::ADDR_W-1:0]    source_addr,
    input  wire logic [sasf_pkg::BYTES_W-1:0]   byte_count,
    output logic                                q_vld,
    output sasf_pkg::front_item_t               q_item,
    input  wire logic                           q_pop
);
    import sasf_pkg::*;

    logic [1:0]  cnt_reg, cnt_next;
    logic        wr_ptr_reg, rd_ptr_reg;
    front_item_t slot_reg [2];
    front_item_t new_item;
    logic        accept;
    logic        take;

    always_comb
    begin
        new_item.cmd        = command;
        new_item.addr       = source_addr;
        new_item.bytes      = byte_count;
        new_item.needs_scan = command inside {CMD_ADD, CMD_REMOVE, CMD_RECV};
    end

    assign full   = (cnt_reg == 2'd2);
    assign q_vld  = (cnt_reg != 2'd0);
    assign q_item = slot_reg[rd_ptr_reg];
    assign accept = push && !full;
    assign take   = q_pop && q_vld;

    always_comb
    begin
        case ({accept, take})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (take)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

// ----- src/sasf_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sasf_back: table scan, counters and result register
// Carries out one queued command at a time: scans the address table for
// table commands, updates the table and counters, and loads the result.
// ----------------------------------------------------------------------------
module sasf_back #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_vld,
    input  wire sasf_pkg::front_item_t q_item,
    output logic                       q_pop,
    output logic                       empty,
    input  wire logic                  pop,
    output sasf_pkg::result_t          result
);
    import sasf_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] LAST = CW'(TABLE_ENTRIES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]               state_reg, state_next;
    front_item_t              item_reg, item_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic                     cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]            cmp_idx_reg, cmp_idx_next;
    logic                     hit_reg, hit_next;
    logic [IW-1:0]            hit_idx_reg, hit_idx_next;
    logic                     free_found_reg, free_found_next;
    logic [IW-1:0]            free_idx_reg, free_idx_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;

    logic [MSG_W-1:0] round_reg, round_next;
    logic [MSG_W-1:0] sent_msgs_per_reg, sent_msgs_per_next;
    logic [CNT_W-1:0] sent_bytes_per_reg, sent_bytes_per_next;
    logic [MSG_W-1:0] sent_msgs_all_reg, sent_msgs_all_next;
    logic [CNT_W-1:0] sent_bytes_all_reg, sent_bytes_all_next;
    logic [MSG_W-1:0] recv_msgs_per_reg, recv_msgs_per_next;
    logic [CNT_W-1:0] recv_bytes_per_reg, recv_bytes_per_next;
    logic [MSG_W-1:0] recv_msgs_all_reg, recv_msgs_all_next;
    logic [CNT_W-1:0] recv_bytes_all_reg, recv_bytes_all_next;

    logic             out_vld_reg, out_vld_next;
    result_t          res_reg, res_next;

    logic             ram_we;
    logic [IW-1:0]    ram_raddr;
    logic [ADDR_W-1:0] ram_rdata;
    logic             slot_free;
    logic [CNT_W-1:0] bytes_ext;

    sasf_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx_reg),
        .wdata (item_reg.addr),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_raddr = idx_reg[IW-1:0];
    assign slot_free = !out_vld_reg || pop;
    assign bytes_ext = {{(CNT_W - BYTES_W){1'b0}}, item_reg.bytes};
    assign empty     = !out_vld_reg;
    assign result    = res_reg;

    always_comb
    begin
        state_next          = state_reg;
        item_next           = item_reg;
        idx_next            = idx_reg;
        cmp_vld_next        = 1'b0;
        cmp_idx_next        = cmp_idx_reg;
        hit_next            = hit_reg;
        hit_idx_next        = hit_idx_reg;
        free_found_next     = free_found_reg;
        free_idx_next       = free_idx_reg;
        valid_next          = valid_reg;
        round_next          = round_reg;
        sent_msgs_per_next  = sent_msgs_per_reg;
        sent_bytes_per_next = sent_bytes_per_reg;
        sent_msgs_all_next  = sent_msgs_all_reg;
        sent_bytes_all_next = sent_bytes_all_reg;
        recv_msgs_per_next  = recv_msgs_per_reg;
        recv_bytes_per_next = recv_bytes_per_reg;
        recv_msgs_all_next  = recv_msgs_all_reg;
        recv_bytes_all_next = recv_bytes_all_reg;
        out_vld_next        = out_vld_reg;
        res_next            = res_reg;
        q_pop               = 1'b0;
        ram_we              = 1'b0;

        if (pop && out_vld_reg)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_vld)
                begin
                    q_pop           = 1'b1;
                    item_next       = q_item;
                    idx_next        = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = q_item.needs_scan ? S_SCAN : S_DONE;
                end
            end
            S_SCAN:
            begin
                // Addresses are issued one per cycle; the read data of an
                // entry arrives in the cycle after its address.
                if (idx_reg != LAST)
                begin
                    idx_next     = idx_reg + CW'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = idx_reg[IW-1:0];
                    if (!valid_reg[idx_reg[IW-1:0]] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg[IW-1:0];
                    end
                end
                if (cmp_vld_reg && !hit_reg && valid_reg[cmp_idx_reg]
                    && (ram_rdata == item_reg.addr))
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                end
                if ((idx_reg == LAST) && !cmp_vld_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    res_next        = '0;
                    res_next.status = STAT_OK;
                    case (item_reg.cmd)
                        CMD_ADD:
                        begin
                            if (hit_reg)
                            begin
                                res_next.status = STAT_DUP;
                            end
                            else if (free_found_reg)
                            begin
                                ram_we                   = 1'b1;
                                valid_next[free_idx_reg] = 1'b1;
                            end
                            else
                            begin
                                res_next.status = STAT_FULL;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (hit_reg)
                            begin
                                valid_next[hit_idx_reg] = 1'b0;
                            end
                            else
                            begin
                                res_next.status = STAT_NOT_FOUND;
                            end
                        end
                        CMD_RECV:
                        begin
                            if (hit_reg)
                            begin
                                res_next.status = STAT_DROPPED;
                            end
                            else
                            begin
                                recv_msgs_per_next  = recv_msgs_per_reg + MSG_W'(1);
                                recv_msgs_all_next  = recv_msgs_all_reg + MSG_W'(1);
                                recv_bytes_per_next = recv_bytes_per_reg + bytes_ext;
                                recv_bytes_all_next = recv_bytes_all_reg + bytes_ext;
                            end
                        end
                        CMD_SENT:
                        begin
                            sent_msgs_per_next  = sent_msgs_per_reg + MSG_W'(1);
                            sent_msgs_all_next  = sent_msgs_all_reg + MSG_W'(1);
                            sent_bytes_per_next = sent_bytes_per_reg + bytes_ext;
                            sent_bytes_all_next = sent_bytes_all_reg + bytes_ext;
                        end
                        CMD_TICK:
                        begin
                            round_next                     = round_reg + MSG_W'(1);
                            res_next.round_number          = round_reg + MSG_W'(1);
                            res_next.period_msgs_sent      = sent_msgs_per_reg;
                            res_next.period_bytes_sent     = sent_bytes_per_reg;
                            res_next.all_msgs_sent         = sent_msgs_all_reg;
                            res_next.all_bytes_sent        = sent_bytes_all_reg;
                            res_next.period_msgs_received  = recv_msgs_per_reg;
                            res_next.period_bytes_received = recv_bytes_per_reg;
                            res_next.all_msgs_received     = recv_msgs_all_reg;
                            res_next.all_bytes_received    = recv_bytes_all_reg;
                            sent_msgs_per_next             = '0;
                            sent_bytes_per_next            = '0;
                            recv_msgs_per_next             = '0;
                            recv_bytes_per_next            = '0;
                        end
                        default:
                        begin
                            res_next.status = STAT_OK;
                        end
                    endcase
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            cmp_vld_reg        <= 1'b0;
            valid_reg          <= '0;
            out_vld_reg        <= 1'b0;
            round_reg          <= '0;
            sent_msgs_per_reg  <= '0;
            sent_bytes_per_reg <= '0;
            sent_msgs_all_reg  <= '0;
            sent_bytes_all_reg <= '0;
            recv_msgs_per_reg  <= '0;
            recv_bytes_per_reg <= '0;
            recv_msgs_all_reg  <= '0;
            recv_bytes_all_reg <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            cmp_vld_reg        <= cmp_vld_next;
            valid_reg          <= valid_next;
            out_vld_reg        <= out_vld_next;
            round_reg          <= round_next;
            sent_msgs_per_reg  <= sent_msgs_per_next;
            sent_bytes_per_reg <= sent_bytes_per_next;
            sent_msgs_all_reg  <= sent_msgs_all_next;
            sent_bytes_all_reg <= sent_bytes_all_next;
            recv_msgs_per_reg  <= recv_msgs_per_next;
            recv_bytes_per_reg <= recv_bytes_per_next;
            recv_msgs_all_reg  <= recv_msgs_all_next;
            recv_bytes_all_reg <= recv_bytes_all_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        idx_reg        <= idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        res_reg        <= res_next;
    end

endmodule

`default_nettype wire

// ----- src/source_address_filter_with_stats.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// source_address_filter_with_stats: ignored source address table and counters
// Filters received frames against a table of ignored 48-bit source
// addresses and keeps sent and received traffic counters.
// ----------------------------------------------------------------------------
// Each command beat pushed in gives exactly one result beat, in order. Beats
// enter a two-entry queue, so the block keeps taking commands while the back
// end works and while a finished result waits in the result register. The
// back end runs one command at a time. Add, remove and received-frame
// commands scan the whole address table through the single read port of the
// table memory, one entry per cycle. The back end takes such a command from
// the queue, issues the reads, waits for the last read data, which returns
// from the registered read port, closes the scan and loads the result, which
// shows on the result ports at the following edge. Sent-frame, log-tick and
// unknown commands touch only the counters; the back end takes them from the
// queue and then loads the result, with no scan. A result that is not
// popped holds the back end before it loads the next result. Every valid
// entry is checked on an add, so duplicates are always reported; a new
// address goes into the lowest free entry. All counters wrap at their width.
// ----------------------------------------------------------------------------
module source_address_filter_with_stats #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [sasf_pkg::CMD_W-1:0]    command,
    input  wire logic [sasf_pkg::ADDR_W-1:0]   source_addr,
    input  wire logic [sasf_pkg::BYTES_W-1:0]  byte_count,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [sasf_pkg::STAT_W-1:0]        status,
    output logic [sasf_pkg::MSG_W-1:0]         round_number,
    output logic [sasf_pkg::MSG_W-1:0]         period_msgs_sent,
    output logic [sasf_pkg::CNT_W-1:0]         period_bytes_sent,
    output logic [sasf_pkg::MSG_W-1:0]         all_msgs_sent,
    output logic [sasf_pkg::CNT_W-1:0]         all_bytes_sent,
    output logic [sasf_pkg::MSG_W-1:0]         period_msgs_received,
    output logic [sasf_pkg::CNT_W-1:0]         period_bytes_received,
    output logic [sasf_pkg::MSG_W-1:0]         all_msgs_received,
    output logic [sasf_pkg::CNT_W-1:0]         all_bytes_received
);
    import sasf_pkg::*;

    // Handoff between the intake queue and the back end.
    logic        q_vld;
    logic        q_pop;
    front_item_t q_item;
    result_t     result;

    // The front end classifies each command as it is queued, so the back
    // end knows at once whether a table scan is needed.
    sasf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .source_addr (source_addr),
        .byte_count  (byte_count),
        .q_vld       (q_vld),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    // The back end owns the table, the valid bits, the counters and the
    // result register that feeds the result ports.
    sasf_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_vld  (q_vld),
        .q_item (q_item),
        .q_pop  (q_pop),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // Counter fields are zero on every result beat other than a log tick.
    assign status                = result.status;
    assign round_number          = result.round_number;
    assign period_msgs_sent      = result.period_msgs_sent;
    assign period_bytes_sent     = result.period_bytes_sent;
    assign all_msgs_sent         = result.all_msgs_sent;
    assign all_bytes_sent        = result.all_bytes_sent;
    assign period_msgs_received  = result.period_msgs_received;
    assign period_bytes_received = result.period_bytes_received;
    assign all_msgs_received     = result.all_msgs_received;
    assign all_bytes_received    = result.all_bytes_received;

endmodule

`default_nettype wire
